// ===== hw/rtl/ws2812_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and register codes of the ws2812 pixel transmitter
// no dependencies

package ws2812_pkg;

    localparam int BITS_PER_PIXEL = 24;
    localparam int COLOR_BITS     = 24;
    localparam int PAD_BITS       = BITS_PER_PIXEL - COLOR_BITS;
    localparam int IDX_W          = $clog2(BITS_PER_PIXEL);

    localparam int CH_W     = 8;
    localparam int BRIGHT_W = 7;
    localparam int CYC_W    = 10;
    localparam int CFG_W    = CYC_W;

    localparam int QUEUE_DEPTH = 2;

    typedef logic [2:0]            t_cfg_idx;
    typedef logic [CFG_W-1:0]      t_cfg_data;
    typedef logic [CH_W-1:0]       t_chan;
    typedef logic [CYC_W-1:0]      t_cyc;
    typedef logic [COLOR_BITS-1:0] t_grb;

    localparam t_cfg_idx CFG_ENABLE     = 3'd0;
    localparam t_cfg_idx CFG_BRIGHTNESS = 3'd1;
    localparam t_cfg_idx CFG_ONE_HIGH   = 3'd2;
    localparam t_cfg_idx CFG_ONE_LOW    = 3'd3;
    localparam t_cfg_idx CFG_ZERO_HIGH  = 3'd4;
    localparam t_cfg_idx CFG_ZERO_LOW   = 3'd5;

    localparam logic [BRIGHT_W-1:0] RST_BRIGHTNESS = 7'd30;
    localparam t_cyc RST_ONE_HIGH  = 10'd168;
    localparam t_cyc RST_ONE_LOW   = 10'd144;
    localparam t_cyc RST_ZERO_HIGH = 10'd84;
    localparam t_cyc RST_ZERO_LOW  = 10'd192;

    typedef struct packed {
        logic                enable;
        logic [BRIGHT_W-1:0] brightness;
        t_cyc                one_high;
        t_cyc                one_low;
        t_cyc                zero_high;
        t_cyc                zero_low;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic full;
    } t_queue_status;

endpackage

// ===== hw/rtl/ws2812_if.sv =====
`timescale 1ns / 1ps
// channel interfaces: pixel input and pulse descriptor output
// depends on ws2812_pkg

interface ws2812_pixel_if;
    import ws2812_pkg::*;
    logic  valid;
    logic  ready;
    t_chan red;
    t_chan green;
    t_chan blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface ws2812_pulse_if;
    import ws2812_pkg::*;
    logic valid;
    logic ready;
    logic bit_value;
    t_cyc high_cycles;
    t_cyc low_cycles;
    logic last_bit;

    modport source (output valid, output bit_value, output high_cycles, output low_cycles,
                    output last_bit, input ready);
    modport sink   (input valid, input bit_value, input high_cycles, input low_cycles,
                    input last_bit, output ready);
endinterface

// ===== hw/rtl/ws2812_front.sv =====
`timescale 1ns / 1ps
// front end: accepts a pixel, applies enable and brightness, packs grb word
// depends on ws2812_pkg and ws2812_pixel_if

module ws2812_front
    import ws2812_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    ws2812_pixel_if.sink      i_pixel,
    input  t_cfg              i_cfg,
    input  t_queue_status     i_qstat,
    output logic              o_push,
    output t_grb              o_word
);

    localparam int PROD_W      = CH_W + BRIGHT_W;
    localparam int RECIP_W     = 13;
    localparam int MUL_W       = PROD_W + RECIP_W;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP = 13'd5243;
    localparam int QUOT_W      = CH_W + 1;

    logic              r_valid, n_valid;
    logic [PROD_W-1:0] r_prod_r, r_prod_g, r_prod_b;
    logic [PROD_W-1:0] n_prod_r, n_prod_g, n_prod_b;
    logic              w_accept;

    // floor(p / 100) by reciprocal, saturated to one channel
    function automatic t_chan scale_div(input logic [PROD_W-1:0] p);
        logic [MUL_W-1:0]  m;
        logic [QUOT_W-1:0] q;
        m = MUL_W'(p) * MUL_W'(RECIP);
        q = m[RECIP_SHIFT +: QUOT_W];
        return q[QUOT_W-1] ? {CH_W{1'b1}} : q[CH_W-1:0];
    endfunction

    assign i_pixel.ready = !r_valid || !i_qstat.full;
    assign w_accept      = i_pixel.valid && i_pixel.ready;
    assign o_push        = r_valid && !i_qstat.full;
    assign o_word        = {scale_div(r_prod_g), scale_div(r_prod_r), scale_div(r_prod_b)};

    always_comb begin
        n_valid  = r_valid;
        n_prod_r = r_prod_r;
        n_prod_g = r_prod_g;
        n_prod_b = r_prod_b;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (w_accept) begin
            n_valid = 1'b1;
            if (i_cfg.enable) begin
                n_prod_r = PROD_W'(i_pixel.red)   * PROD_W'(i_cfg.brightness);
                n_prod_g = PROD_W'(i_pixel.green) * PROD_W'(i_cfg.brightness);
                n_prod_b = PROD_W'(i_pixel.blue)  * PROD_W'(i_cfg.brightness);
            end else begin
                n_prod_r = '0;
                n_prod_g = '0;
                n_prod_b = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_r <= n_prod_r;
        r_prod_g <= n_prod_g;
        r_prod_b <= n_prod_b;
    end

endmodule

// ===== hw/rtl/ws2812_queue.sv =====
`timescale 1ns / 1ps
// short fifo of packed grb words between front and back
// depends on ws2812_pkg

module ws2812_queue
    import ws2812_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_grb          i_wdata,
    input  logic          i_pop,
    output t_grb          o_rdata,
    output t_queue_status o_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_grb             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_stat.valid = (r_count != '0);
    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_rdata      = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

// ===== hw/rtl/ws2812_back.sv =====
`timescale 1ns / 1ps
// back end: shifts a grb word out as one pulse descriptor per bit
// depends on ws2812_pkg and ws2812_pulse_if

module ws2812_back
    import ws2812_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  t_queue_status i_qstat,
    input  t_grb          i_word,
    output logic          o_pop,
    ws2812_pulse_if.source o_pulse
);

    logic                      r_busy, n_busy;
    logic [BITS_PER_PIXEL-1:0] r_word, n_word;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic                      w_fire;
    logic                      w_last;
    logic                      w_bit;

    assign w_fire = o_pulse.valid && o_pulse.ready;
    assign w_last = (r_idx == IDX_W'(BITS_PER_PIXEL - 1));
    assign w_bit  = r_word[BITS_PER_PIXEL-1];
    assign o_pop  = i_qstat.valid && (!r_busy || (w_fire && w_last));

    assign o_pulse.valid       = r_busy;
    assign o_pulse.bit_value   = w_bit;
    assign o_pulse.high_cycles = w_bit ? i_cfg.one_high : i_cfg.zero_high;
    assign o_pulse.low_cycles  = w_bit ? i_cfg.one_low  : i_cfg.zero_low;
    assign o_pulse.last_bit    = w_last;

    always_comb begin
        n_busy = r_busy;
        n_word = r_word;
        n_idx  = r_idx;
        if (o_pop) begin
            n_busy = 1'b1;
            n_word = BITS_PER_PIXEL'(i_word) << PAD_BITS;
            n_idx  = '0;
        end else if (w_fire) begin
            n_word = r_word << 1;
            n_idx  = r_idx + 1'b1;
            if (w_last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    a_stall_holds_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !o_pulse.ready) |=> ($stable(r_idx) && $stable(r_word)))
        else $error("bit position moved during output stall");

    a_pop_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_busy || (w_fire && w_last)))
        else $error("word loaded while a pixel is still in flight");

    a_mid_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && !w_last) |=> (r_busy && r_idx != '0))
        else $error("pixel ended before its last bit");

    a_last_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_last && !i_qstat.valid) |=> !r_busy)
        else $error("descriptor shown with no pixel loaded");

endmodule

// ===== hw/rtl/ws2812_pixel_transmitter_top.sv =====
`timescale 1ns / 1ps
// top level of the ws2812 pixel transmitter: configuration registers,
// front end, word queue and bit shifter
// depends on ws2812_pkg, ws2812_if, ws2812_front, ws2812_queue, ws2812_back
//
// usage:
//   i_pixel carries one rgb pixel per transaction (valid/ready).
//   o_pulse carries one pulse descriptor per transaction: bit value, high
//   and low durations in clock cycles and a last-bit mark. each pixel gives
//   BITS_PER_PIXEL descriptors, grb order, msb first, trailing pad bits zero.
//   configuration must be written through i_cfg_we/i_cfg_idx/i_cfg_data
//   only while the block is idle (not enforced); unknown indexes are ignored.
// path: when the block is empty a pixel passes the front product register,
//   the queue and the shifter register before its first descriptor is valid.
// throughput: one descriptor per cycle while o_pulse.ready is high, set by
//   the output bit shifter; the next word is loaded in the cycle the last bit
//   of the previous one is taken.
// reset: registers return to enable 1, brightness 30, timings 168/144/84/192,
//   queue and shifter empty.
// stall: a stalled descriptor is held; up to two scaled pixels wait in the
//   queue and one in the front register before i_pixel.ready drops.

module ws2812_pixel_transmitter_top
    import ws2812_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    ws2812_pixel_if.sink   i_pixel,
    ws2812_pulse_if.source o_pulse,
    input  logic           i_cfg_we,
    input  t_cfg_idx       i_cfg_idx,
    input  t_cfg_data      i_cfg_data
);

    t_cfg          r_cfg, n_cfg;
    t_queue_status w_qstat;
    logic          w_push;
    logic          w_pop;
    t_grb          w_wdata;
    t_grb          w_rdata;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE:     n_cfg.enable     = i_cfg_data[0];
                CFG_BRIGHTNESS: n_cfg.brightness = i_cfg_data[BRIGHT_W-1:0];
                CFG_ONE_HIGH:   n_cfg.one_high   = i_cfg_data[CYC_W-1:0];
                CFG_ONE_LOW:    n_cfg.one_low    = i_cfg_data[CYC_W-1:0];
                CFG_ZERO_HIGH:  n_cfg.zero_high  = i_cfg_data[CYC_W-1:0];
                CFG_ZERO_LOW:   n_cfg.zero_low   = i_cfg_data[CYC_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable     <= 1'b1;
            r_cfg.brightness <= RST_BRIGHTNESS;
            r_cfg.one_high   <= RST_ONE_HIGH;
            r_cfg.one_low    <= RST_ONE_LOW;
            r_cfg.zero_high  <= RST_ZERO_HIGH;
            r_cfg.zero_low   <= RST_ZERO_LOW;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    ws2812_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pixel (i_pixel),
        .i_cfg   (r_cfg),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_word  (w_wdata)
    );

    ws2812_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_wdata),
        .i_pop   (w_pop),
        .o_rdata (w_rdata),
        .o_stat  (w_qstat)
    );

    ws2812_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_qstat (w_qstat),
        .i_word  (w_rdata),
        .o_pop   (w_pop),
        .o_pulse (o_pulse)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// testbench of the ws2812 pixel transmitter: drives pixels, predicts the grb pulse
// descriptor train of each pixel and checks every output transaction in order
// depends on ws2812_pkg, ws2812_if and ws2812_pixel_transmitter_top

module tb;
    import ws2812_pkg::*;

    localparam int unsigned PERCENT_FULL = 100;
    localparam int          LIMIT_CYCLES = 600000;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          RANDOM_PHASES = 10;
    localparam int          PIXELS_PER_PHASE = 32;

    // indexes with no register behind them
    localparam t_cfg_idx CFG_UNUSED_6 = 3'd6;
    localparam t_cfg_idx CFG_UNUSED_7 = 3'd7;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_pixel;

    typedef struct packed {
        logic bit_value;
        t_cyc high_cycles;
        t_cyc low_cycles;
        logic last_bit;
    } t_pulse;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_idx;
    t_cfg_data i_cfg_data;

    ws2812_pixel_if pix_ch ();
    ws2812_pulse_if pulse_ch ();

    ws2812_pixel_transmitter_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pixel    (pix_ch),
        .o_pulse    (pulse_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_cfg   shadow_cfg;
    t_pixel pending_pixels[$];
    t_pulse expected_pulses[$];
    t_pulse got_pulse;
    t_pulse want_pulse;
    logic   hold_pixel;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int          mismatch_count;
    int          pixels_sent;
    int          pulses_checked;
    int          cfg_settings;
    int          cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endfunction

    function automatic t_chan scale_level(t_chan level);
        int unsigned v;
        v = (32'(level) * 32'(shadow_cfg.brightness)) / PERCENT_FULL;
        if (v > 255) begin
            v = 255;
        end
        return t_chan'(v);
    endfunction

    // grb word, msb first, pad bits zero
    function automatic void predict_pulse_train(t_pixel px);
        t_chan                     r;
        t_chan                     g;
        t_chan                     b;
        logic [BITS_PER_PIXEL-1:0] word;
        t_pulse                    p;
        r = scale_level(shadow_cfg.enable ? px.red   : t_chan'(0));
        g = scale_level(shadow_cfg.enable ? px.green : t_chan'(0));
        b = scale_level(shadow_cfg.enable ? px.blue  : t_chan'(0));
        word = '0;
        word[BITS_PER_PIXEL-1 -: COLOR_BITS] = {g, r, b};
        for (int k = 0; k < BITS_PER_PIXEL; k++) begin
            p.bit_value   = word[BITS_PER_PIXEL-1-k];
            p.high_cycles = p.bit_value ? shadow_cfg.one_high : shadow_cfg.zero_high;
            p.low_cycles  = p.bit_value ? shadow_cfg.one_low  : shadow_cfg.zero_low;
            p.last_bit    = (k == BITS_PER_PIXEL - 1);
            expected_pulses.push_back(p);
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
        end else begin
            hold_pixel = pix_ch.valid;
            if (pix_ch.valid && pix_ch.ready) begin
                predict_pulse_train(pending_pixels.pop_front());
                pixels_sent++;
                hold_pixel = 1'b0;
            end
            if (!hold_pixel) begin
                if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    pix_ch.valid <= 1'b1;
                    pix_ch.red   <= pending_pixels[0].red;
                    pix_ch.green <= pending_pixels[0].green;
                    pix_ch.blue  <= pending_pixels[0].blue;
                end else begin
                    pix_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pulse_ch.ready <= 1'b0;
        end else begin
            if (pulse_ch.valid && pulse_ch.ready) begin
                got_pulse = '{pulse_ch.bit_value, pulse_ch.high_cycles,
                              pulse_ch.low_cycles, pulse_ch.last_bit};
                if (expected_pulses.size() == 0) begin
                    report_mismatch($sformatf("unexpected descriptor bit %0d high %0d low %0d last %0d",
                        got_pulse.bit_value, got_pulse.high_cycles, got_pulse.low_cycles,
                        got_pulse.last_bit));
                end else begin
                    want_pulse = expected_pulses.pop_front();
                    pulses_checked++;
                    if (got_pulse !== want_pulse) begin
                        report_mismatch($sformatf(
                            "expected bit %0d high %0d low %0d last %0d, got bit %0d high %0d low %0d last %0d",
                            want_pulse.bit_value, want_pulse.high_cycles, want_pulse.low_cycles,
                            want_pulse.last_bit, got_pulse.bit_value, got_pulse.high_cycles,
                            got_pulse.low_cycles, got_pulse.last_bit));
                    end
                end
            end
            pulse_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, t_cfg_data data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_ENABLE:     shadow_cfg.enable     = data[0];
            CFG_BRIGHTNESS: shadow_cfg.brightness = data[BRIGHT_W-1:0];
            CFG_ONE_HIGH:   shadow_cfg.one_high   = data;
            CFG_ONE_LOW:    shadow_cfg.one_low    = data;
            CFG_ZERO_HIGH:  shadow_cfg.zero_high  = data;
            CFG_ZERO_LOW:   shadow_cfg.zero_low   = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_timings(t_cyc one_high, t_cyc one_low, t_cyc zero_high, t_cyc zero_low);
        write_reg(CFG_ONE_HIGH, one_high);
        write_reg(CFG_ONE_LOW, one_low);
        write_reg(CFG_ZERO_HIGH, zero_high);
        write_reg(CFG_ZERO_LOW, zero_low);
        cfg_settings++;
    endtask

    task automatic queue_pixel(t_chan r, t_chan g, t_chan b);
        t_pixel px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        pending_pixels.push_back(px);
    endtask

    // block idle: nothing pending, nothing expected, pipeline flushed
    task automatic wait_idle();
        while (pending_pixels.size() != 0 || pix_ch.valid || expected_pulses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_chan rand_level();
        int unsigned pick;
        pick = $urandom_range(15);
        if (pick == 0) begin
            return 8'd0;
        end else if (pick == 1) begin
            return 8'd255;
        end
        return t_chan'($urandom_range(255));
    endfunction

    function automatic t_cyc rand_cycles();
        int unsigned pick;
        pick = $urandom_range(15);
        if (pick == 0) begin
            return 10'd0;
        end else if (pick == 1) begin
            return 10'd1;
        end else if (pick == 2) begin
            return 10'd1023;
        end
        return t_cyc'($urandom_range(1023));
    endfunction

    initial begin
        int unsigned pick;
        logic [BRIGHT_W-1:0] bright;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_ENABLE;
        i_cfg_data     = '0;
        pix_ch.valid   = 1'b0;
        pix_ch.red     = '0;
        pix_ch.green   = '0;
        pix_ch.blue    = '0;
        pulse_ch.ready = 1'b0;
        mismatch_count = 0;
        pixels_sent    = 0;
        pulses_checked = 0;
        cfg_settings   = 1;
        cycle_count    = 0;
        send_idle_pct  = 26;
        recv_idle_pct  = 81;

        shadow_cfg.enable     = 1'b1;
        shadow_cfg.brightness = RST_BRIGHTNESS;
        shadow_cfg.one_high   = RST_ONE_HIGH;
        shadow_cfg.one_low    = RST_ONE_LOW;
        shadow_cfg.zero_high  = RST_ZERO_HIGH;
        shadow_cfg.zero_low   = RST_ZERO_LOW;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'h80, 8'h01, 8'hFE);
        queue_pixel(8'h12, 8'h34, 8'h56);
        wait_idle();

        // full brightness, extreme timings
        write_reg(CFG_BRIGHTNESS, 10'd100);
        write_timings(10'd1, 10'd1023, 10'd1023, 10'd1);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'hAA, 8'h55, 8'h0F);
        wait_idle();

        // brightness above 100 saturates, zero durations, unknown indexes ignored
        write_reg(CFG_BRIGHTNESS, 10'd127);
        write_timings(10'd0, 10'd1023, 10'd1023, 10'd0);
        write_reg(CFG_UNUSED_6, 10'h3FF);
        write_reg(CFG_UNUSED_7, 10'h155);
        queue_pixel(8'd255, 8'd201, 8'd200);
        queue_pixel(8'd1, 8'd2, 8'd3);
        wait_idle();

        // disabled: black regardless of colour, upper data bits dropped
        write_reg(CFG_ENABLE, 10'h3FE);
        write_reg(CFG_BRIGHTNESS, 10'h364);
        cfg_settings++;
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'h5A, 8'hA5, 8'h3C);
        wait_idle();

        // zero and minimum brightness
        write_reg(CFG_ENABLE, 10'h001);
        write_reg(CFG_BRIGHTNESS, 10'd0);
        cfg_settings++;
        queue_pixel(8'd255, 8'd255, 8'd255);
        wait_idle();
        write_reg(CFG_BRIGHTNESS, 10'd1);
        cfg_settings++;
        queue_pixel(8'd255, 8'd200, 8'd99);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase < 4) begin
                send_idle_pct = 26;
                recv_idle_pct = 81;
            end else if (phase < 7) begin
                send_idle_pct = 81;
                recv_idle_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            write_reg(CFG_ENABLE, {9'($urandom_range(511)), 1'($urandom_range(99) < 80)});
            pick = $urandom_range(9);
            if (pick == 0) begin
                bright = 7'd0;
            end else if (pick == 1) begin
                bright = 7'd100;
            end else if (pick == 2) begin
                bright = 7'd127;
            end else begin
                bright = 7'($urandom_range(127));
            end
            write_reg(CFG_BRIGHTNESS, {3'($urandom_range(7)), bright});
            write_timings(rand_cycles(), rand_cycles(), rand_cycles(), rand_cycles());
            if ($urandom_range(99) < 30) begin
                write_reg($urandom_range(1) ? CFG_UNUSED_6 : CFG_UNUSED_7,
                          t_cfg_data'($urandom_range(1023)));
            end

            for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
                queue_pixel(rand_level(), rand_level(), rand_level());
            end
            wait_idle();
        end

        if (expected_pulses.size() != 0) begin
            report_mismatch($sformatf("%0d descriptors never arrived", expected_pulses.size()));
        end

        $display("run covered %0d pixels and %0d pulse descriptors over %0d register settings",
                 pixels_sent, pulses_checked, cfg_settings);
        $display("mismatches: %0d", mismatch_count);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ws2812_pkg.sv
hw/rtl/ws2812_if.sv
hw/rtl/ws2812_front.sv
hw/rtl/ws2812_queue.sv
hw/rtl/ws2812_back.sv
hw/rtl/ws2812_pixel_transmitter_top.sv
sim/tb.sv
